// ===== rtl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared constants, register codes and the divider cell record for the
// corner gradient generator.
// ----------------------------------------------------------------------------
package bgc_pkg;

	localparam int MAX_DIMENSION = 4096;
	localparam int COORD_W       = $clog2(MAX_DIMENSION);
	localparam int DIM_W         = COORD_W + 1;
	localparam int WPROD_W       = 2 * COORD_W;
	localparam int NUM_W         = WPROD_W + 8;
	localparam int Q_W           = 8;
	localparam int DSH_W         = WPROD_W + Q_W - 1;
	localparam int N_CHAN        = 3;
	localparam int ADDR_W        = 5;

	localparam logic [2:0] REG_TOP_LEFT     = 3'd0;
	localparam logic [2:0] REG_TOP_RIGHT    = 3'd1;
	localparam logic [2:0] REG_BOTTOM_RIGHT = 3'd2;
	localparam logic [2:0] REG_BOTTOM_LEFT  = 3'd3;
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd4;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd5;

	typedef struct packed {
		logic [N_CHAN-1:0][NUM_W-1:0] rem;
		logic [DSH_W-1:0]             dsh;
		logic [N_CHAN-1:0][Q_W-1:0]   quo;
	} bgc_cell_t;

	// Clamp a frame dimension into 1 .. MAX_DIMENSION.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0) r = DIM_W'(1);
		else if (d > DIM_W'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
		return r;
	endfunction

endpackage

// ===== rtl/bgc_ifs.sv =====
// ----------------------------------------------------------------------------
// bgc channel interfaces
// Pixel request channel and colour result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bgc_pix_if import bgc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface bgc_col_if ();
	logic        valid;
	logic        ready;
	logic [7:0]  red_level;
	logic [7:0]  green_level;
	logic [7:0]  blue_level;
	logic [31:0] packed_colour;
	modport source (output valid, red_level, green_level, blue_level, packed_colour,
		input ready);
	modport sink (input valid, red_level, green_level, blue_level, packed_colour,
		output ready);
endinterface

// ===== rtl/bilinear_corner_gradient_core.sv =====
// ----------------------------------------------------------------------------
// bilinear_corner_gradient_core
// Requests pass registered stages for weights, products and sums, then
// eight divider cells, one quotient bit each.
// Throughput one request per cycle; the whole pipe holds while a result
// waits unaccepted. Reset clears valid flags and loads the default corner
// colours and a 320 by 240 frame.
// ----------------------------------------------------------------------------
module bilinear_corner_gradient_core import bgc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	bgc_pix_if.sink           pix,
	bgc_col_if.source         col
);

	logic [2:0][23:0] corner_q;  // tl, tr, br
	logic [DIM_W-1:0] width_q, height_q;
	logic [2:0]       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q[0] <= 24'hFF0000;
			corner_q[1] <= 24'h0000FF;
			corner_q[2] <= 24'h00FF00;
			width_q     <= DIM_W'(320);
			height_q    <= DIM_W'(240);
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_TOP_LEFT:     corner_q[0] <= pwdata[23:0];
				REG_TOP_RIGHT:    corner_q[1] <= pwdata[23:0];
				REG_BOTTOM_RIGHT: corner_q[2] <= pwdata[23:0];
				REG_FRAME_WIDTH:  width_q     <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: height_q    <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	logic [23:0] bl_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bl_q <= 24'hFFFF00;
		else if (psel && penable && pwrite && reg_idx == REG_BOTTOM_LEFT) bl_q <= pwdata[23:0];
	end

	always_comb begin
		case (reg_idx)
			REG_TOP_LEFT:     prdata = {8'd0, corner_q[0]};
			REG_TOP_RIGHT:    prdata = {8'd0, corner_q[1]};
			REG_BOTTOM_RIGHT: prdata = {8'd0, corner_q[2]};
			REG_BOTTOM_LEFT:  prdata = {8'd0, bl_q};
			REG_FRAME_WIDTH:  prdata = 32'(width_q);
			REG_FRAME_HEIGHT: prdata = 32'(height_q);
			default:          prdata = '0;
		endcase
	end

	// Pipe advances whenever the output register is free or being drained.
	logic en;
	assign en        = !col.valid || col.ready;
	assign pix.ready = en;

	// Stage 1: clamp coordinates, form axis weights.
	logic [DIM_W-1:0]   wc, hc;
	logic [COORD_W-1:0] xlim, ylim, xc, yc, dw, dh;
	always_comb begin
		wc   = clamp_dim(width_q);
		hc   = clamp_dim(height_q);
		xlim = COORD_W'(wc - DIM_W'(1));
		ylim = COORD_W'(hc - DIM_W'(1));
		xc   = (pix.pixel_x > xlim) ? xlim : pix.pixel_x;
		yc   = (pix.pixel_y > ylim) ? ylim : pix.pixel_y;
		dw   = (wc > DIM_W'(1)) ? xlim : COORD_W'(1);
		dh   = (hc > DIM_W'(1)) ? ylim : COORD_W'(1);
	end

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [COORD_W-1:0] wl_s1, wr_s1, wt_s1, wb_s1, dw_s1, dh_s1;
	logic [3:0][WPROD_W-1:0] p_s2;  // tl, tr, br, bl area weights
	logic [WPROD_W-1:0] den_s2, den_s3, den_s4;
	logic [N_CHAN-1:0][3:0][NUM_W-1:0] m_s3;
	logic [N_CHAN-1:0][NUM_W-1:0] num_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wl_s1 <= dw - xc;
			wr_s1 <= xc;
			wt_s1 <= dh - yc;
			wb_s1 <= yc;
			dw_s1 <= dw;
			dh_s1 <= dh;
			p_s2[0] <= wt_s1 * wl_s1;
			p_s2[1] <= wt_s1 * wr_s1;
			p_s2[2] <= wb_s1 * wr_s1;
			p_s2[3] <= wb_s1 * wl_s1;
			den_s2  <= dw_s1 * dh_s1;
			den_s3  <= den_s2;
			den_s4  <= den_s3;
			for (int c = 0; c < N_CHAN; c++) begin
				m_s3[c][0] <= NUM_W'(corner_q[0][8*(2-c) +: 8]) * NUM_W'(p_s2[0]);
				m_s3[c][1] <= NUM_W'(corner_q[1][8*(2-c) +: 8]) * NUM_W'(p_s2[1]);
				m_s3[c][2] <= NUM_W'(corner_q[2][8*(2-c) +: 8]) * NUM_W'(p_s2[2]);
				m_s3[c][3] <= NUM_W'(bl_q[8*(2-c) +: 8]) * NUM_W'(p_s2[3]);
				num_s4[c]  <= m_s3[c][0] + m_s3[c][1] + m_s3[c][2] + m_s3[c][3];
			end
		end
	end

	// Divider chain: quotient never exceeds 255, so eight cells settle it.
	bgc_cell_t chain [0:Q_W];
	logic      vchain [0:Q_W];

	always_comb begin
		chain[0].rem = num_s4;
		chain[0].dsh = DSH_W'({den_s4, {(Q_W-1){1'b0}}});
		chain[0].quo = '0;
		vchain[0]    = v_s4;
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_cell
		bgc_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.up_vld  (vchain[k]),
			.up_data (chain[k]),
			.dn_vld  (vchain[k+1]),
			.dn_data (chain[k+1])
		);
	end

	assign col.valid         = vchain[Q_W];
	assign col.red_level     = chain[Q_W].quo[0];
	assign col.green_level   = chain[Q_W].quo[1];
	assign col.blue_level    = chain[Q_W].quo[2];
	assign col.packed_colour = {8'hFF, chain[Q_W].quo[0], chain[Q_W].quo[1],
		chain[Q_W].quo[2]};

endmodule

// ===== rtl/bgc_div_cell.sv =====
// ----------------------------------------------------------------------------
// bgc_div_cell
// One restoring-division step for all three channels: settle one quotient
// bit and hand remainder and halved divisor to the next cell.
// ----------------------------------------------------------------------------
module bgc_div_cell import bgc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      up_vld,
	input  bgc_cell_t up_data,
	output logic      dn_vld,
	output bgc_cell_t dn_data
);

	bgc_cell_t nxt;

	always_comb begin
		nxt.dsh = up_data.dsh >> 1;
		for (int c = 0; c < N_CHAN; c++) begin
			if (up_data.rem[c] >= NUM_W'(up_data.dsh)) begin
				nxt.rem[c] = up_data.rem[c] - NUM_W'(up_data.dsh);
				nxt.quo[c] = {up_data.quo[c][Q_W-2:0], 1'b1};
			end else begin
				nxt.rem[c] = up_data.rem[c];
				nxt.quo[c] = {up_data.quo[c][Q_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dn_vld <= 1'b0;
		else if (en) dn_vld <= up_vld;
	end

	always_ff @(posedge clk) begin
		if (en) dn_data <= nxt;
	end

endmodule

// ===== test/bilinear_corner_gradient_core_tb.sv =====
// ----------------------------------------------------------------------------
// bilinear_corner_gradient_core_tb
// Sends pixel requests with random idling and stalls, predicts each colour
// by exact integer bilinear blending and compares results in order.
// ----------------------------------------------------------------------------
module bilinear_corner_gradient_core_tb;
	import bgc_pkg::*;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
	} pix_req_t;

	typedef struct packed {
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [31:0] word;
	} colour_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bgc_pix_if pix ();
	bgc_col_if col ();

	bilinear_corner_gradient_core i_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pix(pix.sink), .col(col.source)
	);

	// shadow of the corner colours and frame size
	logic [23:0] corner_tl, corner_tr, corner_br, corner_bl;
	logic [12:0] frame_w, frame_h;

	pix_req_t req_q[$];
	colour_t  colour_q[$];
	int       send_idle_pct, recv_idle_pct;
	int       hold_off;
	int       n_err;
	int       n_cycles;
	bit       sent_one;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > 400000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [12:0] span_of(input logic [12:0] d);
		logic [12:0] c;
		c = (d == 0) ? 13'd1 : (d > 13'd4096 ? 13'd4096 : d);
		return c;
	endfunction

	function automatic logic [7:0] blend_channel(input int sh, input longint x,
			input longint y, input longint dw, input longint dh);
		longint num, v;
		num = longint'((corner_tl >> sh) & 8'hFF) * (dh - y) * (dw - x)
			+ longint'((corner_bl >> sh) & 8'hFF) * y * (dw - x)
			+ longint'((corner_tr >> sh) & 8'hFF) * (dh - y) * x
			+ longint'((corner_br >> sh) & 8'hFF) * y * x;
		v = num / (dw * dh);
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic colour_t gradient_colour(input pix_req_t p);
		colour_t c;
		longint  w, h, x, y, dw, dh;
		w = span_of(frame_w);
		h = span_of(frame_h);
		x = p.x;
		y = p.y;
		if (x > w - 1) x = w - 1;
		if (y > h - 1) y = h - 1;
		dw = (w > 1) ? w - 1 : 1;
		dh = (h > 1) ? h - 1 : 1;
		c.r = blend_channel(16, x, y, dw, dh);
		c.g = blend_channel(8, x, y, dw, dh);
		c.b = blend_channel(0, x, y, dw, dh);
		c.word = {8'hFF, c.r, c.g, c.b};
		return c;
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
		end else begin
			if (sent_one || !pix.valid) begin
				sent_one = 1'b0;
				if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pix.valid   <= 1'b1;
					pix.pixel_x <= req_q[0].x;
					pix.pixel_y <= req_q[0].y;
					colour_q.insert(colour_q.size(), gradient_colour(req_q.pop_front()));
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// acceptance flag, sampled at the rising edge
	always @(posedge clk) begin
		if (pix.valid && pix.ready) sent_one = 1'b1;
	end

	always @(negedge clk) begin
		if (hold_off > 0) begin
			col.ready <= 1'b0;
			hold_off  <= hold_off - 1;
		end else begin
			col.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		colour_t want;
		if (arst_n && col.valid && col.ready) begin
			if (colour_q.size() == 0) begin
				n_err = n_err + 1;
				if (n_err <= 10) $display("unexpected colour %h", col.packed_colour);
			end else begin
				want = colour_q.pop_front();
				if (col.red_level !== want.r || col.green_level !== want.g
						|| col.blue_level !== want.b || col.packed_colour !== want.word) begin
					n_err = n_err + 1;
					if (n_err <= 10)
						$display("mismatch: want %h %h %h %h got %h %h %h %h",
							want.r, want.g, want.b, want.word, col.red_level,
							col.green_level, col.blue_level, col.packed_colour);
				end
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TOP_LEFT:     corner_tl = val[23:0];
			REG_TOP_RIGHT:    corner_tr = val[23:0];
			REG_BOTTOM_RIGHT: corner_br = val[23:0];
			REG_BOTTOM_LEFT:  corner_bl = val[23:0];
			REG_FRAME_WIDTH:  frame_w = val[12:0];
			REG_FRAME_HEIGHT: frame_h = val[12:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (req_q.size() == 0 && !pix.valid && colour_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic queue_req(input int x, input int y);
		pix_req_t p;
		p.x = 12'(x);
		p.y = 12'(y);
		req_q.insert(req_q.size(), p);
	endtask

	task automatic queue_random(input int n);
		repeat (n) begin
			if ($urandom_range(3) == 0) queue_req($urandom, $urandom);
			else queue_req($urandom_range(span_of(frame_w)), $urandom_range(span_of(frame_h)));
		end
	endtask

	task automatic set_frame(input logic [31:0] w, input logic [31:0] h);
		reg_write(REG_FRAME_WIDTH, w);
		reg_write(REG_FRAME_HEIGHT, h);
	endtask

	task automatic set_corners_random();
		reg_write(REG_TOP_LEFT, $urandom);
		reg_write(REG_TOP_RIGHT, $urandom);
		reg_write(REG_BOTTOM_RIGHT, $urandom);
		reg_write(REG_BOTTOM_LEFT, $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		pix.valid = 1'b0; pix.pixel_x = '0; pix.pixel_y = '0; col.ready = 1'b0;
		corner_tl = 24'hFF0000; corner_tr = 24'h0000FF;
		corner_br = 24'h00FF00; corner_bl = 24'hFFFF00;
		frame_w = 13'd320; frame_h = 13'd240;
		n_err = 0; n_cycles = 0; hold_off = 0; sent_one = 1'b0;
		send_idle_pct = 6; recv_idle_pct = 49;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset gradient: corners, extremes, out of frame
		queue_req(0, 0); queue_req(319, 0); queue_req(0, 239); queue_req(319, 239);
		queue_req(12'hFFF, 12'hFFF); queue_req(160, 120); queue_req(12'hAAA, 12'h555);
		queue_req(12'h555, 12'hAAA);
		drain();

		// white corners on the largest frame; full-scale sums
		reg_write(REG_TOP_LEFT, 32'hFFFFFF); reg_write(REG_TOP_RIGHT, 32'hFFFFFF);
		reg_write(REG_BOTTOM_RIGHT, 32'hFFFFFF); reg_write(REG_BOTTOM_LEFT, 32'hFFFFFF);
		set_frame(4096, 4096);
		queue_req(0, 0); queue_req(4095, 4095); queue_req(2047, 1); queue_req(1, 4094);
		drain();

		// single-pixel frame, zero and oversized dimensions, black 2 by 2 frame
		set_corners_random();
		set_frame(1, 1);
		queue_req(0, 0); queue_req(12'hFFF, 12'h7);
		drain();
		set_frame(0, 2);
		queue_req(5, 0); queue_req(5, 1);
		drain();
		set_frame(32'h1FFF, 1);
		queue_req(4095, 3); queue_req(100, 0);
		drain();
		reg_write(REG_TOP_LEFT, 0); reg_write(REG_TOP_RIGHT, 0);
		reg_write(REG_BOTTOM_RIGHT, 0); reg_write(REG_BOTTOM_LEFT, 0);
		set_frame(2, 2);
		queue_req(0, 1); queue_req(1, 0);
		drain();

		// random phases; hold the receiver off while requests pile up
		set_corners_random();
		set_frame(17, 9);
		hold_off = 300;
		queue_random(150);
		drain();
		send_idle_pct = 49; recv_idle_pct = 6;
		set_corners_random();
		set_frame($urandom_range(4097, 1), $urandom_range(4097, 1));
		queue_random(150);
		drain();
		send_idle_pct = 0; recv_idle_pct = 0;
		set_corners_random();
		set_frame($urandom_range(64, 1), $urandom_range(64, 1));
		queue_random(130);
		drain();

		if (n_err == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bgc_pkg.sv
rtl/bgc_ifs.sv
rtl/bgc_div_cell.sv
rtl/bilinear_corner_gradient_core.sv
test/bilinear_corner_gradient_core_tb.sv
